// File: design/psg_pkg.sv
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types, constants and the attenuation table of the tone/noise
// sound generator.
// ----------------------------------------------------------------------------
package psg_pkg;

  localparam int STEP_W    = 24;  // ticks per frame, Q16
  localparam int FRAC_W    = 16;
  localparam int TICKS_W   = 9;   // whole ticks per frame, 0..256
  localparam int PERIOD_W  = 10;
  localparam int COUNTER_W = 11;
  localparam int VOL_W     = 4;
  localparam int LEVEL_W   = 15;  // table amplitude
  localparam int NOISE_W   = 16;
  localparam int MIX_W     = 18;  // sum of four signed amplitudes
  localparam int SAMPLE_W  = 16;
  localparam int NUM_CH    = 4;
  localparam int CMD_VAL_W = 6;

  localparam logic [STEP_W-1:0]   STEP_RESET  = 24'd332469;
  localparam logic [NOISE_W-1:0]  NOISE_RESET = 16'h8000;
  localparam logic [VOL_W-1:0]    VOL_MUTE    = 4'hF;
  localparam logic [1:0]          NOISE_CH    = 2'd3;
  localparam logic [1:0]          NOISE_SEL_TONE2 = 2'd3;
  localparam logic signed [MIX_W-1:0] SAMPLE_MAX = 18'sd32767;
  localparam logic signed [MIX_W-1:0] SAMPLE_MIN = -18'sd32767;
  localparam logic signed [MIX_W-1:0] MIX_LIMIT  = 18'sd131068;

  typedef enum logic [1:0] {
    CMD_FRAME     = 2'd0,
    CMD_VOLUME    = 2'd1,
    CMD_PERIOD_LO = 2'd2,
    CMD_PERIOD_HI = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [1:0]           ch;
    logic [CMD_VAL_W-1:0] value;
  } cmd_t;

  // 2 dB attenuation steps; code 15 is muted
  function automatic logic [LEVEL_W-1:0] vol_level(input logic [VOL_W-1:0] v);
    logic [LEVEL_W-1:0] lv;
    case (v)
      4'd0:    lv = 15'd32767;
      4'd1:    lv = 15'd26028;
      4'd2:    lv = 15'd20675;
      4'd3:    lv = 15'd16422;
      4'd4:    lv = 15'd13045;
      4'd5:    lv = 15'd10362;
      4'd6:    lv = 15'd8231;
      4'd7:    lv = 15'd6538;
      4'd8:    lv = 15'd5193;
      4'd9:    lv = 15'd4125;
      4'd10:   lv = 15'd3277;
      4'd11:   lv = 15'd2603;
      4'd12:   lv = 15'd2067;
      4'd13:   lv = 15'd1642;
      4'd14:   lv = 15'd1304;
      default: lv = 15'd0;
    endcase
    return lv;
  endfunction

endpackage

// File: design/psg_cmd_fifo.sv
// ----------------------------------------------------------------------------
// psg_cmd_fifo
// Small command queue between the byte decoder and the generator engine.
// ----------------------------------------------------------------------------
module psg_cmd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  psg_pkg::cmd_t  wdata,
  output logic           full,
  input  logic           pop,
  output psg_pkg::cmd_t  rdata,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  psg_pkg::cmd_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: design/psg_front.sv
// ----------------------------------------------------------------------------
// psg_front
// Request decoder: tracks the latch state and turns each byte write or
// frame request into an engine command, but for a data byte on the noise period.
// ----------------------------------------------------------------------------
module psg_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic                in_action,
  input  logic [7:0]          in_data_byte,
  input  logic                q_full,
  output logic                cmd_push,
  output psg_pkg::cmd_t       cmd_wdata
);

  logic [1:0]    latch_ch_r, latch_ch_nxt;
  logic          latch_vol_r, latch_vol_nxt;
  logic          accept;
  logic          cmd_valid;
  psg_pkg::cmd_t cmd;

  assign accept = in_push && !q_full;

  always_comb begin
    latch_ch_nxt  = latch_ch_r;
    latch_vol_nxt = latch_vol_r;
    cmd_valid     = 1'b1;
    cmd.kind      = psg_pkg::CMD_FRAME;
    cmd.ch        = latch_ch_r;
    cmd.value     = in_data_byte[5:0];
    if (!in_action) begin
      if (in_data_byte[7]) begin
        // latch byte: new channel/type plus low nibble
        latch_ch_nxt  = in_data_byte[6:5];
        latch_vol_nxt = in_data_byte[4];
        cmd.ch        = in_data_byte[6:5];
        cmd.value     = {2'b00, in_data_byte[3:0]};
        cmd.kind      = in_data_byte[4] ? psg_pkg::CMD_VOLUME : psg_pkg::CMD_PERIOD_LO;
      end else if (latch_vol_r) begin
        cmd.kind  = psg_pkg::CMD_VOLUME;
        cmd.value = {2'b00, in_data_byte[3:0]};
      end else if (latch_ch_r != psg_pkg::NOISE_CH) begin
        cmd.kind = psg_pkg::CMD_PERIOD_HI;
      end else begin
        // data byte on the noise period does nothing
        cmd_valid = 1'b0;
      end
    end
  end

  assign cmd_push  = accept && cmd_valid;
  assign cmd_wdata = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_ch_r  <= '0;
      latch_vol_r <= 1'b0;
    end else if (accept) begin
      latch_ch_r  <= latch_ch_nxt;
      latch_vol_r <= latch_vol_nxt;
    end
  end

endmodule

// File: design/psg_back.sv
// ----------------------------------------------------------------------------
// psg_back
// Generator engine: applies register commands, runs one generator tick per
// cycle for a frame, mixes the channels and holds the sample for output.
// ----------------------------------------------------------------------------
module psg_back (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cmd_empty,
  input  psg_pkg::cmd_t                          cmd_rdata,
  output logic                                   cmd_pop,
  input  logic [psg_pkg::STEP_W-1:0]             ticks_per_frame,
  output logic                                   out_empty,
  input  logic                                   out_pop,
  output logic signed [psg_pkg::SAMPLE_W-1:0]    out_mixed_sample
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_MIX,
    S_OUT
  } state_t;

  state_t                             state_r, state_nxt;
  logic [psg_pkg::PERIOD_W-1:0]       period_r  [psg_pkg::NUM_CH];
  logic [psg_pkg::PERIOD_W-1:0]       period_nxt[psg_pkg::NUM_CH];
  logic [psg_pkg::COUNTER_W-1:0]      counter_r  [psg_pkg::NUM_CH];
  logic [psg_pkg::COUNTER_W-1:0]      counter_nxt[psg_pkg::NUM_CH];
  logic [psg_pkg::NUM_CH-1:0]         level_r, level_nxt;
  logic [psg_pkg::VOL_W-1:0]          volume_r  [psg_pkg::NUM_CH];
  logic [psg_pkg::VOL_W-1:0]          volume_nxt[psg_pkg::NUM_CH];
  logic [psg_pkg::NOISE_W-1:0]        noise_r, noise_nxt;
  logic [psg_pkg::FRAC_W-1:0]         frac_r, frac_nxt;
  logic [psg_pkg::TICKS_W-1:0]        ticks_r, ticks_nxt;
  logic signed [psg_pkg::MIX_W-1:0]   sum_r, sum_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic signed [psg_pkg::SAMPLE_W-1:0] sample_r, sample_nxt;

  logic [psg_pkg::FRAC_W+psg_pkg::STEP_W-16:0] acc; // 25 bits
  logic [psg_pkg::PERIOD_W-1:0]       new_period;
  logic [1:0]                         noise_sel;
  logic [psg_pkg::COUNTER_W-1:0]      noise_rate;
  logic                               noise_fb;
  logic [psg_pkg::NOISE_W-1:0]        noise_shifted;
  logic signed [psg_pkg::MIX_W-1:0]   mix_sum;
  logic signed [psg_pkg::MIX_W-1:0]   term;
  logic signed [psg_pkg::MIX_W-1:0]   rounded;
  logic signed [psg_pkg::MIX_W-1:0]   quot;
  logic signed [psg_pkg::MIX_W-1:0]   clamped;
  logic                               out_free;

  assign cmd_pop  = (state_r == S_IDLE) && !cmd_empty;
  assign out_free = !out_valid_r || out_pop;

  // noise lane helpers
  assign noise_sel     = period_r[psg_pkg::NOISE_CH][1:0];
  assign noise_rate    = (noise_sel == psg_pkg::NOISE_SEL_TONE2)
                         ? {1'b0, period_r[2]}
                         : (psg_pkg::COUNTER_W'(16) << noise_sel);
  assign noise_fb      = period_r[psg_pkg::NOISE_CH][2] ? (noise_r[0] ^ noise_r[3])
                                                        : noise_r[0];
  assign noise_shifted = {noise_fb, noise_r[psg_pkg::NOISE_W-1:1]};

  assign acc = {9'b0, frac_r} + {1'b0, ticks_per_frame};

  // mix of the current levels
  always_comb begin
    mix_sum = '0;
    term    = '0;
    for (int ch = 0; ch < psg_pkg::NUM_CH; ch++) begin
      term = $signed({3'b000, psg_pkg::vol_level(volume_r[ch])});
      if (volume_r[ch] != psg_pkg::VOL_MUTE) begin
        mix_sum = level_r[ch] ? (mix_sum + term) : (mix_sum - term);
      end
    end
  end

  // divide by four toward zero, then clamp
  assign rounded = sum_r[psg_pkg::MIX_W-1] ? (sum_r + 18'sd3) : sum_r;
  assign quot    = rounded >>> 2;
  assign clamped = (quot > psg_pkg::SAMPLE_MAX) ? psg_pkg::SAMPLE_MAX :
                   (quot < psg_pkg::SAMPLE_MIN) ? psg_pkg::SAMPLE_MIN : quot;

  always_comb begin
    state_nxt     = state_r;
    period_nxt    = period_r;
    counter_nxt   = counter_r;
    level_nxt     = level_r;
    volume_nxt    = volume_r;
    noise_nxt     = noise_r;
    frac_nxt      = frac_r;
    ticks_nxt     = ticks_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r && !out_pop;
    sample_nxt    = sample_r;
    new_period    = period_r[cmd_rdata.ch];

    unique case (state_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          case (cmd_rdata.kind)
            psg_pkg::CMD_FRAME: begin
              frac_nxt  = acc[psg_pkg::FRAC_W-1:0];
              ticks_nxt = acc[psg_pkg::FRAC_W+psg_pkg::TICKS_W-1:psg_pkg::FRAC_W];
              state_nxt = (acc[psg_pkg::FRAC_W+psg_pkg::TICKS_W-1:psg_pkg::FRAC_W] == '0)
                          ? S_MIX : S_TICK;
            end
            psg_pkg::CMD_VOLUME: begin
              volume_nxt[cmd_rdata.ch] = cmd_rdata.value[psg_pkg::VOL_W-1:0];
            end
            psg_pkg::CMD_PERIOD_LO: begin
              new_period = {period_r[cmd_rdata.ch][9:4], cmd_rdata.value[3:0]};
              period_nxt[cmd_rdata.ch] = (new_period == '0) ? 10'd1 : new_period;
            end
            default: begin
              new_period = {cmd_rdata.value, period_r[cmd_rdata.ch][3:0]};
              period_nxt[cmd_rdata.ch] = (new_period == '0) ? 10'd1 : new_period;
            end
          endcase
        end
      end
      S_TICK: begin
        for (int ch = 0; ch < 3; ch++) begin
          if (counter_r[ch][psg_pkg::COUNTER_W-1:1] == '0) begin
            counter_nxt[ch] = {1'b0, period_r[ch]};
            level_nxt[ch]   = !level_r[ch];
          end else begin
            counter_nxt[ch] = counter_r[ch] - 1'b1;
          end
        end
        if (counter_r[psg_pkg::NOISE_CH][psg_pkg::COUNTER_W-1:1] == '0) begin
          counter_nxt[psg_pkg::NOISE_CH] = noise_rate;
          noise_nxt                      = noise_shifted;
          level_nxt[psg_pkg::NOISE_CH]   = noise_shifted[0];
        end else begin
          counter_nxt[psg_pkg::NOISE_CH] = counter_r[psg_pkg::NOISE_CH] - 1'b1;
        end
        ticks_nxt = ticks_r - 1'b1;
        if (ticks_r == psg_pkg::TICKS_W'(1)) begin
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        sum_nxt   = mix_sum;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          sample_nxt    = clamped[psg_pkg::SAMPLE_W-1:0];
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      level_r     <= '0;
      noise_r     <= psg_pkg::NOISE_RESET;
      frac_r      <= '0;
      ticks_r     <= '0;
      out_valid_r <= 1'b0;
      for (int ch = 0; ch < psg_pkg::NUM_CH; ch++) begin
        period_r[ch]  <= '0;
        counter_r[ch] <= '0;
        volume_r[ch]  <= psg_pkg::VOL_MUTE;
      end
    end else begin
      state_r     <= state_nxt;
      period_r    <= period_nxt;
      counter_r   <= counter_nxt;
      level_r     <= level_nxt;
      volume_r    <= volume_nxt;
      noise_r     <= noise_nxt;
      frac_r      <= frac_nxt;
      ticks_r     <= ticks_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sum_r    <= sum_nxt;
    sample_r <= sample_nxt;
  end

  assign out_empty        = !out_valid_r;
  assign out_mixed_sample = sample_r;

  a_tick_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TICK |-> ticks_r != '0)
    else $error("tick state entered with no ticks left");

  a_frame_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished frame did not reach the output register");

  a_mix_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MIX |=> (sum_r <= psg_pkg::MIX_LIMIT && sum_r >= -psg_pkg::MIX_LIMIT))
    else $error("mix sum out of range");

endmodule

// File: design/psg_tone_noise_generator_top.sv
// Three-tone, one-noise sound generator. Requests enter a small command queue
// and are executed in order by the engine: a byte write is applied while the
// engine is idle (a data byte on the noise period makes no command), and a
// frame request runs N = (fraction + ticks_per_frame_q16) >> 16 whole generator
// ticks (0..256, about 5 at the reset step), then mixes the channels. The engine
// runs one generator tick per clock across all four channels. New requests
// are taken while the queue has room; a finished sample waits in the output
// register while the engine moves on, and the next frame's sample waits for its pop.
// ----------------------------------------------------------------------------
// psg_tone_noise_generator_top
// Top level: APB step register, command queue, decoder and engine.
// ----------------------------------------------------------------------------
module psg_tone_noise_generator_top #(
  parameter int CMD_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic                                in_action,
  input  logic [7:0]                          in_data_byte,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [psg_pkg::SAMPLE_W-1:0] out_mixed_sample,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [2:0]                          cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);

  localparam logic REG_TICKS_PER_FRAME = 1'b0;

  logic [psg_pkg::STEP_W-1:0] step_r;
  logic                       cfg_wr;
  logic                       cmd_push;
  logic                       cmd_pop;
  logic                       cmd_full;
  logic                       cmd_empty;
  psg_pkg::cmd_t              cmd_wdata;
  psg_pkg::cmd_t              cmd_rdata;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_TICKS_PER_FRAME) ? {8'b0, step_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= psg_pkg::STEP_RESET;
    end else if (cfg_wr && cfg_paddr[2] == REG_TICKS_PER_FRAME) begin
      step_r <= cfg_pwdata[psg_pkg::STEP_W-1:0];
    end
  end

  assign in_full = cmd_full;

  psg_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_action    (in_action),
    .in_data_byte (in_data_byte),
    .q_full       (cmd_full),
    .cmd_push     (cmd_push),
    .cmd_wdata    (cmd_wdata)
  );

  psg_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_wdata),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  psg_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_empty        (cmd_empty),
    .cmd_rdata        (cmd_rdata),
    .cmd_pop          (cmd_pop),
    .ticks_per_frame  (step_r),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_mixed_sample (out_mixed_sample)
  );

endmodule
